// File: rtl/core/fvn_pkg.sv
// Shared constants, types and the lattice permutation table for fractal value noise.
`default_nettype none
package fvn_pkg;

  // Fraction bits of the coordinate path; matches the 16 fraction bits of frequency.
  localparam int FRAC_BITS       = 16;
  localparam int MAX_OCTAVES_DEF = 8;

  localparam int COORD_W  = 10;
  localparam int SEED_W   = 8;
  localparam int FREQ_W   = 20;
  localparam int OCT_W    = 4;
  localparam int HEIGHT_W = 16;
  localparam int LAT_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [SEED_W-1:0] SEED_RST = SEED_W'(0);
  localparam logic [FREQ_W-1:0] FREQ_RST = FREQ_W'(3277);
  localparam logic [OCT_W-1:0]  OCT_RST  = OCT_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED      = 2'd0,
    CFG_FREQUENCY = 2'd1,
    CFG_OCTAVES   = 2'd2
  } cfg_idx_t;

  localparam logic [LAT_W-1:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,
    8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,
    8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,
    8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,
    8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,
    8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,
    8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,
    8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,
    8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,
    8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,
    8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,
    8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,
    8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
    8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
    8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,
    8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,
    8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,
    8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,
    8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,
    8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
    8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
    8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

endpackage
`default_nettype wire

// File: rtl/core/fractal_value_noise_2d_top.sv
// Fractal value noise: pipelined octave lanes, weighted sum and normalising divider.
//
// Takes one (x_coord, y_coord) request per cycle when the output is not stalled and
// returns one height per request, in order, through a pipeline of scale multiply, row
// lookup, corner lookup, x and y interpolation (all octaves
// side by side as lanes), one accumulation stage per octave, then a four-stage
// restoring divider by (2^octaves - 1), four quotient bits a stage. Every stage has
// its own valid bit, so bubbles close up under back-pressure. Configuration writes are
// taken at any time (cfg_ready is tied high) but must only be made while idle.
`default_nettype none
module fractal_value_noise_2d_top #(
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [fvn_pkg::COORD_W-1:0]     x_coord,
  input  wire logic [fvn_pkg::COORD_W-1:0]     y_coord,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [fvn_pkg::HEIGHT_W-1:0]         height,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fvn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fvn_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int FB      = fvn_pkg::FRAC_BITS;
  localparam int LW      = fvn_pkg::LAT_W;
  localparam int HW      = fvn_pkg::HEIGHT_W;
  localparam int NW      = $clog2(MAX_OCTAVES + 1);
  localparam int CW      = FB + LW;              // wrapped coordinate, Q8.FB
  localparam int VW      = FB + LW;              // interpolated value width
  localparam int ACC_W   = VW + MAX_OCTAVES;
  localparam int D_W     = ACC_W - (FB - 8);
  localparam int DIV_PER = 4;
  localparam int DIV_ST  = HW / DIV_PER;
  localparam int HB      = 5;                    // first accumulation stage
  localparam int DB      = HB + MAX_OCTAVES;     // first divider stage
  localparam int NST     = DB + DIV_ST;

  // configuration
  logic [fvn_pkg::SEED_W-1:0] seed;
  logic [fvn_pkg::FREQ_W-1:0] frequency;
  logic [fvn_pkg::OCT_W-1:0]  octaves;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= fvn_pkg::SEED_RST;
      frequency <= fvn_pkg::FREQ_RST;
      octaves   <= fvn_pkg::OCT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fvn_pkg::CFG_SEED:      seed      <= cfg_data[fvn_pkg::SEED_W-1:0];
        fvn_pkg::CFG_FREQUENCY: frequency <= cfg_data[fvn_pkg::FREQ_W-1:0];
        fvn_pkg::CFG_OCTAVES:   octaves   <= cfg_data[fvn_pkg::OCT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0]          n_oct;
  logic [MAX_OCTAVES:0]   pow_n;
  logic [MAX_OCTAVES-1:0] dvs;

  always_comb begin
    if (octaves == '0) begin
      n_oct = NW'(1);
    end else if (int'(octaves) > MAX_OCTAVES) begin
      n_oct = NW'(MAX_OCTAVES);
    end else begin
      n_oct = NW'(octaves);
    end
    pow_n = (MAX_OCTAVES + 1)'(1) << n_oct;
    dvs   = MAX_OCTAVES'(pow_n - 1'b1);
  end

  // stage valids and per-stage enables
  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = ~vld[NST-1] | out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  // stage 0: scale
  logic [fvn_pkg::COORD_W+fvn_pkg::FREQ_W-1:0] xp, yp;
  logic [CW-1:0] xa0, ya0;

  assign xp = x_coord * frequency;
  assign yp = y_coord * frequency;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xa0 <= xp[CW-1:0];
      ya0 <= yp[CW-1:0];
    end
  end

  // lanes: one per octave, coordinates doubled per lane
  logic [LW-1:0] xi1 [MAX_OCTAVES];
  logic [LW-1:0] r0_1 [MAX_OCTAVES];
  logic [LW-1:0] r1_1 [MAX_OCTAVES];
  logic [FB-1:0] fx1 [MAX_OCTAVES];
  logic [FB-1:0] fy1 [MAX_OCTAVES];
  logic [FB-1:0] fx2 [MAX_OCTAVES];
  logic [FB-1:0] fy2 [MAX_OCTAVES];
  logic [FB-1:0] fy3 [MAX_OCTAVES];
  logic [LW-1:0] s2 [MAX_OCTAVES];
  logic [LW-1:0] t2 [MAX_OCTAVES];
  logic [LW-1:0] u2 [MAX_OCTAVES];
  logic [LW-1:0] v2 [MAX_OCTAVES];
  logic [VW-1:0] lo3 [MAX_OCTAVES];
  logic [VW-1:0] hi3 [MAX_OCTAVES];
  logic [VW-1:0] nvh [MAX_OCTAVES][MAX_OCTAVES];

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
    logic [CW-1:0]   xs, ys;
    logic [LW-1:0]   row0_a, row1_a;
    logic [LW-1:0]   c0, c1;
    logic [FB:0]     wx, wy;
    logic [VW+1:0]   lo_s, hi_s;
    logic [VW+FB+1:0] nv_s;

    assign xs     = CW'(xa0 << i);
    assign ys     = CW'(ya0 << i);
    assign row0_a = ys[CW-1:FB] + seed;
    assign row1_a = ys[CW-1:FB] + seed + LW'(1);

    always_ff @(posedge clk) begin
      if (en[1]) begin
        xi1[i]  <= xs[CW-1:FB];
        fx1[i]  <= xs[FB-1:0];
        fy1[i]  <= ys[FB-1:0];
        r0_1[i] <= fvn_pkg::PERM[row0_a];
        r1_1[i] <= fvn_pkg::PERM[row1_a];
      end
    end

    assign c0 = r0_1[i] + xi1[i];
    assign c1 = r1_1[i] + xi1[i];

    always_ff @(posedge clk) begin
      if (en[2]) begin
        s2[i]  <= fvn_pkg::PERM[c0];
        t2[i]  <= fvn_pkg::PERM[c0 + LW'(1)];
        u2[i]  <= fvn_pkg::PERM[c1];
        v2[i]  <= fvn_pkg::PERM[c1 + LW'(1)];
        fx2[i] <= fx1[i];
        fy2[i] <= fy1[i];
      end
    end

    // weights 1 - f, with f = 0 giving a full unit
    assign wx   = {1'b1, FB'(0)} - {1'b0, fx2[i]};
    assign lo_s = s2[i] * wx + t2[i] * {1'b0, fx2[i]};
    assign hi_s = u2[i] * wx + v2[i] * {1'b0, fx2[i]};

    always_ff @(posedge clk) begin
      if (en[3]) begin
        lo3[i] <= lo_s[VW-1:0];
        hi3[i] <= hi_s[VW-1:0];
        fy3[i] <= fy2[i];
      end
    end

    assign wy   = {1'b1, FB'(0)} - {1'b0, fy3[i]};
    assign nv_s = lo3[i] * wy + hi3[i] * {1'b0, fy3[i]};

    always_ff @(posedge clk) begin
      if (en[4]) begin
        nvh[0][i] <= nv_s[VW+FB-1:FB];
      end
    end
  end

  // weighted sum, Horner form: acc = 2*acc + n_j for each active octave
  logic [ACC_W-1:0] acch [MAX_OCTAVES+1];

  assign acch[0] = '0;

  for (genvar j = 0; j < MAX_OCTAVES; j++) begin : g_acc
    logic [ACC_W-1:0] acc_in;

    assign acc_in = (n_oct > NW'(j)) ? ((acch[j] << 1) + ACC_W'(nvh[j][j])) : acch[j];

    always_ff @(posedge clk) begin
      if (en[HB+j]) begin
        acch[j+1] <= acc_in;
      end
    end

    if (j < MAX_OCTAVES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[HB+j]) begin
          nvh[j+1] <= nvh[j];
        end
      end
    end
  end

  // divide by (2^n - 1); the FB-8 scale bits drop off first
  logic [D_W-1:0]         dvd;
  logic [MAX_OCTAVES-1:0] remd [DIV_ST+1];
  logic [HW-1:0]          lowd [DIV_ST+1];
  logic [HW-1:0]          qd   [DIV_ST+1];

  assign dvd     = acch[MAX_OCTAVES][ACC_W-1:FB-8];
  assign remd[0] = dvd[D_W-1:HW];
  assign lowd[0] = dvd[HW-1:0];
  assign qd[0]   = '0;

  for (genvar k = 0; k < DIV_ST; k++) begin : g_div
    logic [MAX_OCTAVES-1:0] r_nx;
    logic [HW-1:0]          l_nx;
    logic [HW-1:0]          q_nx;

    always_comb begin
      logic [MAX_OCTAVES:0] trial;
      r_nx = remd[k];
      l_nx = lowd[k];
      q_nx = qd[k];
      for (int b = 0; b < DIV_PER; b++) begin
        trial = {r_nx, l_nx[HW-1]};
        l_nx  = l_nx << 1;
        if (trial >= {1'b0, dvs}) begin
          trial = trial - {1'b0, dvs};
          q_nx  = {q_nx[HW-2:0], 1'b1};
        end else begin
          q_nx  = {q_nx[HW-2:0], 1'b0};
        end
        r_nx = trial[MAX_OCTAVES-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[DB+k]) begin
        remd[k+1] <= r_nx;
        lowd[k+1] <= l_nx;
        qd[k+1]   <= q_nx;
      end
    end
  end

  assign height = qd[DIV_ST];

endmodule
`default_nettype wire
